// ===== hw/rtl/mcfr_pkg.sv =====
// Shared types and constants for the motor command frame receiver.
// No dependencies; imported by every module of the block.
package mcfr_pkg;

    localparam logic [7:0] START_BYTE  = 8'hAA;
    localparam logic [7:0] END_BYTE    = 8'h0A;
    localparam logic [3:0] LAST_POS    = 4'd11;
    localparam logic [3:0] CHECK_SLOT  = 4'd9;
    localparam int         FRAME_SLOTS = 10;
    localparam logic [15:0] IDLE_MAX   = 16'hFFFF;

    // Opcode carried in the input tuser.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds carried in the output tuser.
    localparam logic [1:0] KIND_SPEED     = 2'd0;
    localparam logic [1:0] KIND_DAC       = 2'd1;
    localparam logic [1:0] KIND_STOP_MODE = 2'd2;
    localparam logic [1:0] KIND_STOP_TIME = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CLOSED_LOOP = 2'd0;
    localparam logic [1:0] CFG_MANUAL_DAC  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

    localparam logic [7:0]  CLOSED_LOOP_RST = 8'd0;
    localparam logic [7:0]  MANUAL_DAC_RST  = 8'd1;
    localparam logic [15:0] TIMEOUT_RST     = 16'd100;

    // Event passed from the parser to the command unit.
    typedef struct packed {
        logic        is_frame;  // 1: valid frame, 0: millisecond tick
        logic [7:0]  mode;
        logic [63:0] values;    // value_one in the lowest 16 bits
    } t_event;

endpackage

// ===== hw/rtl/mcfr_front.sv =====
// Frame parser: hunts for the start byte, stores the frame and checks it.
// Depends on mcfr_pkg; feeds events into mcfr_queue.
module mcfr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_op,
    input  logic [7:0]      i_byte,
    output logic            o_push,
    output mcfr_pkg::t_event o_event
);
    import mcfr_pkg::*;

    logic [3:0] r_pos, n_pos;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_frame [FRAME_SLOTS];
    logic [3:0] slot;
    logic       frame_ok;

    assign slot     = r_pos - 4'd1;
    assign frame_ok = (i_byte == END_BYTE) && (r_frame[CHECK_SLOT] == r_sum);

    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        o_push = 1'b0;
        if (i_accept) begin
            if (i_op == OP_TICK) begin
                o_push = 1'b1;
            end else if (r_pos == 4'd0) begin
                if (i_byte == START_BYTE) begin
                    n_pos = 4'd1;
                    n_sum = 8'd0;
                end
            end else if (r_pos < LAST_POS) begin
                if (slot < CHECK_SLOT) begin
                    n_sum = r_sum + i_byte;
                end
                n_pos = r_pos + 4'd1;
            end else begin
                n_pos  = 4'd0;
                o_push = frame_ok;
            end
        end
    end

    always_comb begin
        o_event.is_frame = (i_op == OP_BYTE);
        o_event.mode     = r_frame[0];
        o_event.values   = {r_frame[8], r_frame[7], r_frame[6], r_frame[5],
                            r_frame[4], r_frame[3], r_frame[2], r_frame[1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 4'd0;
            r_sum <= 8'd0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    // Frame storage needs no reset: a slot is always written before it is read.
    always_ff @(posedge i_clk) begin
        if (i_accept && (i_op == OP_BYTE) && (r_pos != 4'd0) && (r_pos < LAST_POS)) begin
            r_frame[slot] <= i_byte;
        end
    end

endmodule

// ===== hw/rtl/mcfr_queue.sv =====
// Short event queue between the frame parser and the command unit.
// Depends on mcfr_pkg for the event type.
module mcfr_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mcfr_pkg::t_event i_event,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output mcfr_pkg::t_event o_event
);
    import mcfr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_event        r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_event = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_event;
        end
    end

endmodule

// ===== hw/rtl/mcfr_back.sv =====
// Command unit: idle timer, timeout stop, mode decode and output register.
// Depends on mcfr_pkg; drains events from mcfr_queue.
module mcfr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_q_valid,
    input  mcfr_pkg::t_event i_event,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_kind,
    output logic [63:0]      o_data
);
    import mcfr_pkg::*;

    logic [7:0]  r_closed_code, r_dac_code;
    logic [15:0] r_timeout;
    logic [15:0] r_idle, n_idle;
    logic        r_timed_out, n_timed_out;
    logic        r_valid, n_valid;
    logic [1:0]  r_kind, n_kind;
    logic [63:0] r_data, n_data;
    logic        emit;
    logic [15:0] idle_inc;

    assign o_pop    = i_q_valid && (!r_valid || i_ready);
    assign idle_inc = (r_idle == IDLE_MAX) ? r_idle : r_idle + 16'd1;

    always_comb begin
        n_idle      = r_idle;
        n_timed_out = r_timed_out;
        n_kind      = r_kind;
        n_data      = r_data;
        emit        = 1'b0;
        if (o_pop) begin
            if (i_event.is_frame) begin
                n_idle      = 16'd0;
                n_timed_out = 1'b0;
                emit        = 1'b1;
                n_data      = i_event.values;
                if (i_event.mode == r_closed_code) begin
                    n_kind = KIND_SPEED;
                end else if (i_event.mode == r_dac_code) begin
                    n_kind = KIND_DAC;
                end else begin
                    n_kind = KIND_STOP_MODE;
                    n_data = 64'd0;
                end
            end else begin
                n_idle = idle_inc;
                if (!r_timed_out && (idle_inc > r_timeout)) begin
                    n_timed_out = 1'b1;
                    emit        = 1'b1;
                    n_kind      = KIND_STOP_TIME;
                    n_data      = 64'd0;
                end
            end
        end
        if (emit) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed_code <= CLOSED_LOOP_RST;
            r_dac_code    <= MANUAL_DAC_RST;
            r_timeout     <= TIMEOUT_RST;
            r_idle        <= 16'd0;
            r_timed_out   <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CLOSED_LOOP: r_closed_code <= i_cfg_data[7:0];
                    CFG_MANUAL_DAC:  r_dac_code    <= i_cfg_data[7:0];
                    CFG_TIMEOUT:     r_timeout     <= i_cfg_data;
                    default:         ;
                endcase
            end
            r_idle      <= n_idle;
            r_timed_out <= n_timed_out;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/motor_command_frame_receiver.sv =====
// Top level of the motor command frame receiver: parser, event queue, command unit.
// Depends on mcfr_pkg, mcfr_front, mcfr_queue and mcfr_back.
//
//  Channel   Direction  Beat contents (lowest bit first)
//  s_axis    in         tuser: op; tdata: data_byte
//  m_axis    out        tuser: kind; tdata: value_one, value_two, value_three, value_four
//  cfg       in         i_cfg_index selects register, i_cfg_data holds its value
//
// One input beat is taken per cycle while the event queue has room.
// A command enters the event queue when the beat that ends its frame, or the tick that
// causes it, is accepted, and moves on to the output register driving m_axis once no
// earlier command waits there. Output stalls back up through both into s_axis_tready.
// Synchronous active-low reset clears the parser, the queue and the idle timer.
module motor_command_frame_receiver #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // value_one, value_two, value_three, value_four
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);
    import mcfr_pkg::*;

    logic   accept, push, pop, q_full, q_valid;
    t_event ev_in, ev_out;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    mcfr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (s_axis_tuser),
        .i_byte   (s_axis_tdata),
        .o_push   (push),
        .o_event  (ev_in)
    );

    mcfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (ev_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_event (ev_out)
    );

    mcfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_event     (ev_out),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_kind      (m_axis_tuser),
        .o_data      (m_axis_tdata)
    );

endmodule
